@@ src/fscm_pkg.sv @@
// Shared types and constants of the focus scene-change monitor.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fscm_pkg;

  // widths that the register map fixes
  localparam int RATIO_BITS    = 8;
  localparam int FRAME_BITS    = 10;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PEAK_VALUE     = 3'd0,
    REG_CHANGE_RATIO   = 3'd1,
    REG_STABLE_RATIO   = 3'd2,
    REG_CHANGE_FRAMES  = 3'd3,
    REG_STABLE_FRAMES  = 3'd4,
    REG_TIMEOUT_FRAMES = 3'd5
  } fscm_reg_idx_t;

  // register reset values
  localparam logic [RATIO_BITS-1:0] CHANGE_RATIO_RST   = 8'd77;
  localparam logic [RATIO_BITS-1:0] STABLE_RATIO_RST   = 8'd26;
  localparam logic [FRAME_BITS-1:0] CHANGE_FRAMES_RST  = 10'd30;
  localparam logic [FRAME_BITS-1:0] STABLE_FRAMES_RST  = 10'd15;
  localparam logic [FRAME_BITS-1:0] TIMEOUT_FRAMES_RST = 10'd300;

  // ratio and limit settings handed from the register file to the tracker
  typedef struct packed {
    logic [RATIO_BITS-1:0] change_ratio;
    logic [RATIO_BITS-1:0] stable_ratio;
    logic [FRAME_BITS-1:0] change_frames;
    logic [FRAME_BITS-1:0] stable_frames;
    logic [FRAME_BITS-1:0] timeout_frames;
  } fscm_limits_t;

endpackage

`default_nettype wire

@@ src/fscm_cfg_regs.sv @@
// Configuration register file of the focus scene-change monitor.
// Depends on fscm_pkg for register indexes, reset values and the limits struct.
`default_nettype none

module fscm_cfg_regs
  import fscm_pkg::*;
#(
  parameter int VALUE_BITS = 31
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [CFG_IDX_BITS-1:0]  wr_index,
  input  wire logic [CFG_DATA_BITS-1:0] wr_data,
  output logic      [VALUE_BITS-1:0]    peak_value,
  output fscm_limits_t                  limits
);

  // one register per index, unknown indexes drop the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_value            <= '0;
      limits.change_ratio   <= CHANGE_RATIO_RST;
      limits.stable_ratio   <= STABLE_RATIO_RST;
      limits.change_frames  <= CHANGE_FRAMES_RST;
      limits.stable_frames  <= STABLE_FRAMES_RST;
      limits.timeout_frames <= TIMEOUT_FRAMES_RST;
    end else if (wr_en) begin
      case (fscm_reg_idx_t'(wr_index))
        REG_PEAK_VALUE:     peak_value            <= wr_data[VALUE_BITS-1:0];
        REG_CHANGE_RATIO:   limits.change_ratio   <= wr_data[RATIO_BITS-1:0];
        REG_STABLE_RATIO:   limits.stable_ratio   <= wr_data[RATIO_BITS-1:0];
        REG_CHANGE_FRAMES:  limits.change_frames  <= wr_data[FRAME_BITS-1:0];
        REG_STABLE_FRAMES:  limits.stable_frames  <= wr_data[FRAME_BITS-1:0];
        REG_TIMEOUT_FRAMES: limits.timeout_frames <= wr_data[FRAME_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/fscm_ratio_cmp.sv @@
// Exact relative-deviation compare: |a - b| * 256 against ref_val * ratio.
// Depends on fscm_pkg for the ratio width.
`default_nettype none

module fscm_ratio_cmp
  import fscm_pkg::*;
#(
  parameter int VALUE_BITS = 31
) (
  input  wire logic [VALUE_BITS-1:0] a,
  input  wire logic [VALUE_BITS-1:0] b,
  input  wire logic [VALUE_BITS-1:0] ref_val,
  input  wire logic [RATIO_BITS-1:0] ratio,
  output logic                       above,
  output logic                       below
);

  localparam int PROD_BITS = VALUE_BITS + RATIO_BITS;

  logic [VALUE_BITS-1:0] diff;
  logic [PROD_BITS-1:0]  diff_scaled;
  logic [PROD_BITS-1:0]  bound;

  // absolute difference, scaled by one in Q0.8
  assign diff        = (a >= b) ? (a - b) : (b - a);
  assign diff_scaled = {diff, {RATIO_BITS{1'b0}}};

  // reference times ratio, full width so nothing is truncated
  assign bound = {{RATIO_BITS{1'b0}}, ref_val} * {{VALUE_BITS{1'b0}}, ratio};

  assign above = diff_scaled > bound;
  assign below = diff_scaled < bound;

endmodule

`default_nettype wire

@@ src/fscm_tracker.sv @@
// Frame tracker: change and stable counters, timeout and pending state.
// Depends on fscm_pkg and two fscm_ratio_cmp instances.
`default_nettype none

module fscm_tracker
  import fscm_pkg::*;
#(
  parameter int VALUE_BITS = 31,
  parameter int COUNT_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire logic [VALUE_BITS-1:0] sharpness,
  input  wire logic [VALUE_BITS-1:0] peak_value,
  input  wire fscm_limits_t          limits,
  output logic                       refocus,
  output logic                       pending
);

  localparam int CMP_BITS = (COUNT_BITS > FRAME_BITS) ? COUNT_BITS : FRAME_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic                  pending_flag, pending_flag_next;
  logic [COUNT_BITS-1:0] change_count, change_count_next;
  logic [COUNT_BITS-1:0] stable_count, stable_count_next;
  logic [COUNT_BITS-1:0] timeout_count, timeout_count_next;
  logic [VALUE_BITS-1:0] previous_value, previous_value_next;
  logic                  is_changed, is_stable;
  logic                  change_below_unused, stable_above_unused;
  logic                  refocus_hit;

  // deviation from peak while idle
  fscm_ratio_cmp #(.VALUE_BITS(VALUE_BITS)) u_change_cmp (
    .a       (sharpness),
    .b       (peak_value),
    .ref_val (peak_value),
    .ratio   (limits.change_ratio),
    .above   (is_changed),
    .below   (change_below_unused)
  );

  // frame-to-frame deviation while pending
  fscm_ratio_cmp #(.VALUE_BITS(VALUE_BITS)) u_stable_cmp (
    .a       (previous_value),
    .b       (sharpness),
    .ref_val (previous_value),
    .ratio   (limits.stable_ratio),
    .above   (stable_above_unused),
    .below   (is_stable)
  );

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
    count_up = (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic reached(input logic [COUNT_BITS-1:0] c,
                                   input logic [FRAME_BITS-1:0] lim);
    reached = CMP_BITS'(c) >= CMP_BITS'(lim);
  endfunction

  // next state for the frame in flight
  always_comb begin
    pending_flag_next   = pending_flag;
    change_count_next   = change_count;
    stable_count_next   = stable_count;
    timeout_count_next  = timeout_count;
    previous_value_next = previous_value;
    refocus_hit         = 1'b0;

    // idle: look for a lasting change against the peak
    if (!pending_flag) begin
      if (is_changed) begin
        change_count_next = count_up(change_count);
        if (reached(change_count_next, limits.change_frames)) begin
          change_count_next = '0;
          pending_flag_next = 1'b1;
        end
      end else begin
        change_count_next = '0;
      end
    end

    // pending, including the frame that entered it: wait for the scene to settle
    if (pending_flag_next) begin
      stable_count_next   = is_stable ? count_up(stable_count) : '0;
      previous_value_next = sharpness;
      if (reached(stable_count_next, limits.stable_frames)) begin
        stable_count_next  = '0;
        timeout_count_next = '0;
        pending_flag_next  = 1'b0;
        refocus_hit        = 1'b1;
      end else begin
        timeout_count_next = count_up(timeout_count);
        if (reached(timeout_count_next, limits.timeout_frames)) begin
          timeout_count_next = '0;
          pending_flag_next  = 1'b0;
        end
      end
    end
  end

  // state registers, updated once per frame
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_flag   <= 1'b0;
      change_count   <= '0;
      stable_count   <= '0;
      timeout_count  <= '0;
      previous_value <= '0;
    end else if (advance) begin
      pending_flag   <= pending_flag_next;
      change_count   <= change_count_next;
      stable_count   <= stable_count_next;
      timeout_count  <= timeout_count_next;
      previous_value <= previous_value_next;
    end
  end

  assign refocus = refocus_hit;
  assign pending = pending_flag_next;

endmodule

`default_nettype wire

@@ src/focus_scene_change_monitor_core.sv @@
// Top level of the focus scene-change monitor: input register, tracker, result register.
// Depends on fscm_pkg, fscm_cfg_regs and fscm_tracker.
//
//  channel  direction  handshake            payload
//  in       to block   in_valid / in_stall  sharpness
//  out      from block out_valid/out_stall  refocus_now, change_pending
//  cfg      to block   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One frame per cycle sustained while out is not stalled; a frame passes from the input
// register through the tracker update into the result register, from which it transfers out.
// rst is synchronous and clears state, counters, valid flags and configuration registers
// to their reset values; the input value and result payload registers are not reset.
// A stall on out holds the result; in stalls only when the input register cannot move.
// cfg_ready is always high.
`default_nettype none

module focus_scene_change_monitor_core
  import fscm_pkg::*;
#(
  parameter int VALUE_BITS = 31,
  parameter int COUNT_BITS = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [VALUE_BITS-1:0]    sharpness,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          refocus_now,
  output logic                          change_pending,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic                  s1_valid, s1_valid_next;
  logic [VALUE_BITS-1:0] s1_value;
  logic                  s1_advance;
  logic                  in_take;
  logic                  out_valid_next;
  logic [VALUE_BITS-1:0] peak_value;
  fscm_limits_t          limits;
  logic                  refocus_calc, pending_calc;

  assign cfg_ready = 1'b1;

  fscm_cfg_regs #(.VALUE_BITS(VALUE_BITS)) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (cfg_valid && cfg_ready),
    .wr_index   (cfg_index),
    .wr_data    (cfg_data),
    .peak_value (peak_value),
    .limits     (limits)
  );

  // flow control between the two register stages
  assign s1_advance     = s1_valid && (!out_valid || !out_stall);
  assign in_stall       = s1_valid && !s1_advance;
  assign in_take        = in_valid && !in_stall;
  assign s1_valid_next  = in_take || (s1_valid && !s1_advance);
  assign out_valid_next = s1_advance || (out_valid && out_stall);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_value <= sharpness;
    end
  end

  fscm_tracker #(.VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS)) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_advance),
    .sharpness  (s1_value),
    .peak_value (peak_value),
    .limits     (limits),
    .refocus    (refocus_calc),
    .pending    (pending_calc)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      refocus_now    <= refocus_calc;
      change_pending <= pending_calc;
    end
  end

  // a refocus always closes the pending period
  a_refocus_clears_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && refocus_now |-> !change_pending)
    else $error("refocus result with change still pending");

  // the tracker only moves when the result register can take the frame
  a_advance_has_room: assert property (@(posedge clk) disable iff (rst)
    s1_advance |-> (!out_valid || !out_stall))
    else $error("tracker advanced into an occupied result register");

  // a held frame in the input register is carried into the next cycle
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid)
    else $error("stalled input frame lost");

endmodule

`default_nettype wire
